/* src/lru_key_tracker_assert.svh */
// ----------------------------------------------------------------------------
// lru_key_tracker assertion macros
// Shared concurrent assertion forms for the tracker modules.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TRACKER_ASSERT_SVH
`define LRU_KEY_TRACKER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LKT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define LKT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lkt_pkg.sv */
// ----------------------------------------------------------------------------
// lkt_pkg
// Types and constants shared by the LRU key tracker controller and datapath.
// ----------------------------------------------------------------------------
package lkt_pkg;

    localparam int unsigned EVK_BITS  = 16;   // width of the reported evicted key
    localparam int unsigned CFG_BITS  = 4;    // width of the capacity register
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_lkt_state;

    // controller -> datapath
    typedef struct packed {
        logic load_key;
        logic scan_clr;
        logic scan_step;
        logic commit;
    } t_lkt_cmd;

    // datapath -> controller
    typedef struct packed {
        logic last_addr;
        logic out_free;
    } t_lkt_sts;

endpackage

/* src/lkt_ctrl.sv */
// ----------------------------------------------------------------------------
// lkt_ctrl
// Sequencer for one access: accept, scan the key store, drain, commit.
// ----------------------------------------------------------------------------
`include "lru_key_tracker_assert.svh"

module lkt_ctrl
    import lkt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_lkt_sts i_sts,
    output t_lkt_cmd o_cmd
);

    t_lkt_state r_state;
    t_lkt_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_key = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last_addr) begin
                    n_state = S_DRAIN;
                end
            end
            // last read word is compared here
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `LKT_ASSERT_NXT(a_accept_starts_scan, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_in_valid, r_state == S_SCAN,
        "accepted item did not start a scan")
    `LKT_ASSERT_NXT(a_scan_ends, i_clk, i_rst_n,
        (r_state == S_SCAN) && i_sts.last_addr, r_state == S_DRAIN,
        "scan did not end at last address")
    `LKT_ASSERT_NXT(a_commit_returns, i_clk, i_rst_n,
        (r_state == S_COMMIT) && i_sts.out_free, r_state == S_IDLE,
        "commit did not return to idle")

endmodule

/* src/lkt_dpath.sv */
// ----------------------------------------------------------------------------
// lkt_dpath
// Key store, recency ranks, scan registers, capacity register and result
// register of the LRU key tracker.
// ----------------------------------------------------------------------------
`include "lru_key_tracker_assert.svh"

module lkt_dpath
    import lkt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 8,
    parameter int unsigned KEY_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_lkt_cmd            i_cmd,
    output t_lkt_sts            o_sts,
    input  logic [KEY_BITS-1:0] i_key,
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic                o_out_hit,
    output logic                o_out_evicted,
    output logic [EVK_BITS-1:0] o_out_evicted_key
);

    localparam int unsigned IW = $clog2(MAX_ENTRIES);
    localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned CW = (FW > CFG_BITS) ? FW : CFG_BITS;

    // key store: one read and one write port
    logic [KEY_BITS-1:0] r_mem [0:MAX_ENTRIES-1];
    logic [KEY_BITS-1:0] r_rd_data;

    logic [KEY_BITS-1:0]    r_key;
    logic [IW-1:0]          r_scan_idx;
    logic [IW-1:0]          r_cmp_idx;
    logic                   r_cmp_vld;
    logic                   r_hit_fnd;
    logic [IW-1:0]          r_hit_idx;
    logic [IW-1:0]          r_hit_rank;
    logic                   r_lru_fnd;
    logic [IW-1:0]          r_lru_idx;
    logic [IW-1:0]          r_lru_rank;
    logic [KEY_BITS-1:0]    r_lru_key;
    logic                   r_free_fnd;
    logic [IW-1:0]          r_free_idx;
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IW-1:0]          r_rank [0:MAX_ENTRIES-1];
    logic [FW-1:0]          r_fill;
    logic [CFG_BITS-1:0]    r_cfg;
    logic                   r_out_vld;
    logic                   r_out_hit;
    logic                   r_out_evd;
    logic [EVK_BITS-1:0]    r_out_key;

    logic                         cmp_valid;
    logic [IW-1:0]                cmp_rank;
    logic [CW-1:0]                cap_eff;
    logic                         full;
    logic                         do_evict;
    logic                         do_ins;
    logic [IW-1:0]                ins_slot;
    logic [KEY_BITS+EVK_BITS-1:0] lru_key_ext;

    assign o_sts.last_addr = (r_scan_idx == IW'(MAX_ENTRIES - 1));
    assign o_sts.out_free  = !r_out_vld || i_out_ready;

    assign cmp_valid = r_valid[r_cmp_idx];
    assign cmp_rank  = r_rank[r_cmp_idx];

    // capacity of zero acts as one, above the store size as the store size
    always_comb begin
        if (r_cfg == '0) begin
            cap_eff = CW'(1);
        end else if (CW'(r_cfg) > CW'(MAX_ENTRIES)) begin
            cap_eff = CW'(MAX_ENTRIES);
        end else begin
            cap_eff = CW'(r_cfg);
        end
    end

    assign full        = CW'(r_fill) >= cap_eff;
    assign do_evict    = !r_hit_fnd && full && r_lru_fnd;
    assign do_ins      = !r_hit_fnd && (do_evict || r_free_fnd);
    assign ins_slot    = do_evict ? r_lru_idx : r_free_idx;
    assign lru_key_ext = {{EVK_BITS{1'b0}}, r_lru_key};

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[r_scan_idx];
        if (i_cmd.commit && do_ins) begin
            r_mem[ins_slot] <= r_key;
        end
    end

    // scan: address issued one cycle, word compared the next
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_step;
        end
        if (i_cmd.load_key) begin
            r_key <= i_key;
        end
        r_cmp_idx <= r_scan_idx;
        if (i_cmd.scan_clr) begin
            r_scan_idx <= '0;
            r_hit_fnd  <= 1'b0;
            r_lru_fnd  <= 1'b0;
            r_free_fnd <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan_idx <= r_scan_idx + IW'(1);
            end
            if (r_cmp_vld) begin
                if (cmp_valid && (r_rd_data == r_key) && !r_hit_fnd) begin
                    r_hit_fnd  <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_rank <= cmp_rank;
                end
                // ties go to the later slot
                if (cmp_valid && (!r_lru_fnd || (cmp_rank >= r_lru_rank))) begin
                    r_lru_fnd  <= 1'b1;
                    r_lru_idx  <= r_cmp_idx;
                    r_lru_rank <= cmp_rank;
                    r_lru_key  <= r_rd_data;
                end
                if (!cmp_valid && !r_free_fnd) begin
                    r_free_fnd <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
            end
        end
    end

    // rank lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fill  <= '0;
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (r_hit_fnd) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IW'(i) == r_hit_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
            end else if (do_ins) begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (IW'(i) == ins_slot) begin
                        r_valid[i] <= 1'b1;
                        r_rank[i]  <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IW'(1);
                    end
                end
                // an eviction reuses its slot, so the fill stays put
                if (!do_evict) begin
                    r_fill <= r_fill + FW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_cfg <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.commit) begin
            r_out_hit <= r_hit_fnd;
            r_out_evd <= do_evict;
            r_out_key <= do_evict ? lru_key_ext[EVK_BITS-1:0] : '0;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_out_hit         = r_out_hit;
    assign o_out_evicted     = r_out_evd;
    assign o_out_evicted_key = r_out_key;

    `LKT_ASSERT_NOW(a_fill_matches_valid, i_clk, i_rst_n,
        1'b1, $countones(r_valid) == 32'(r_fill),
        "fill count differs from number of valid slots")
    `LKT_ASSERT_NXT(a_hit_no_evict, i_clk, i_rst_n,
        i_cmd.commit && r_hit_fnd,
        r_out_vld && r_out_hit && !r_out_evd && (r_out_key == '0),
        "hit result carries an eviction")
    `LKT_ASSERT_NXT(a_evict_keeps_fill, i_clk, i_rst_n,
        i_cmd.commit && do_evict, r_fill == $past(r_fill),
        "eviction changed the fill count")

endmodule

/* src/lru_key_tracker.sv */
// ----------------------------------------------------------------------------
// lru_key_tracker
// Fully associative least-recently-used tracker for bare keys.
// ----------------------------------------------------------------------------
// Each item on the s_axis side is one access carrying a key. Each access gives
// exactly one item on the m_axis side: tuser[0] is set on a hit, tuser[1] when
// the least recently used key was evicted, and tdata then holds that key.
// A miss inserts the key as most recently used; once the fill reaches the
// capacity in the configuration register, the oldest key is evicted first.
// The capacity is written through i_cfg_wr_en / i_cfg_wr_data; the user must
// write it only while idle, as the block itself does not enforce this.
// An accepted item is scanned against the key store one slot a cycle through
// its single read port, and the next item is taken only once the previous
// one has been committed.
// The result sits in an output register; a new item is accepted while it
// waits, and only the commit of that next item waits for the register to free.
// Reset (synchronous, active low) empties the tracker and sets the capacity to
// 8; the key store itself is not cleared, no slot is marked valid.
// ----------------------------------------------------------------------------
module lru_key_tracker
    import lkt_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES = 8,
    parameter int unsigned KEY_BITS    = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [((KEY_BITS + 7) / 8) * 8-1:0] s_axis_tdata,  // access_key
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [EVK_BITS-1:0]                 m_axis_tdata,  // evicted_key
    output logic [1:0]                          m_axis_tuser,  // hit, evicted
    input  logic                                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0]                 i_cfg_wr_data
);

    t_lkt_cmd cmd;
    t_lkt_sts sts;

    lkt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lkt_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_key             (s_axis_tdata[KEY_BITS-1:0]),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_wr_data     (i_cfg_wr_data),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_out_hit         (m_axis_tuser[0]),
        .o_out_evicted     (m_axis_tuser[1]),
        .o_out_evicted_key (m_axis_tdata)
    );

endmodule

/* tb/lru_key_tracker_tb.sv */
// ----------------------------------------------------------------------------
// lru_key_tracker_tb
// Self-checking testbench for the LRU key tracker. Every accepted access is
// run through a local LRU model. The expected hit / eviction result is queued
// and compared with each item that leaves the master side. Directed accesses
// cover the capacity corner values and a capacity lowered below the fill.
// Random phases at several capacities follow, then a long output stall, a
// drained input pause and a stretch with no idling.
// ----------------------------------------------------------------------------
module lru_key_tracker_tb;
    import lkt_pkg::*;

    localparam int unsigned MAX_ENTRIES  = 8;
    localparam int unsigned KEY_BITS     = 16;
    localparam int unsigned DRAIN_CYCLES = MAX_ENTRIES + 4;
    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned LONG_HOLD    = 150;

    typedef struct packed {
        logic                hit;
        logic                evicted;
        logic [EVK_BITS-1:0] evicted_key;
    } t_access_result;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [KEY_BITS-1:0]  s_axis_tdata  = '0;  // access_key
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [EVK_BITS-1:0]  m_axis_tdata;        // evicted_key
    logic [1:0]           m_axis_tuser;        // hit, evicted
    logic                 i_cfg_wr_en   = 1'b0;
    logic [CFG_BITS-1:0]  i_cfg_wr_data = '0;

    // local copy of the tracker state
    logic [KEY_BITS-1:0]  key_store  [MAX_ENTRIES];
    logic                 slot_valid [MAX_ENTRIES] = '{default: 1'b0};
    logic [2:0]           slot_age   [MAX_ENTRIES] = '{default: 3'd0};
    int unsigned          fill_level       = 0;
    logic [CFG_BITS-1:0]  capacity_setting = CFG_RESET;

    t_access_result       pending_results [$];
    t_access_result       result_want;

    logic [KEY_BITS-1:0]  hot_keys [16];
    int unsigned          hot_count = 1;

    bit                   src_gaps      = 1'b1;
    bit                   sink_gaps     = 1'b1;
    bit                   sink_hold_req = 1'b0;
    int unsigned          hold_left     = 0;
    int unsigned          stall_left    = 0;
    int unsigned          idle_cycles   = 0;

    int unsigned          mismatch_count  = 0;
    int unsigned          items_sent      = 0;
    int unsigned          results_checked = 0;
    int unsigned          hits_seen       = 0;
    int unsigned          evictions_seen  = 0;

    lru_key_tracker #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    // Applies one access to the local state and returns its result.
    function automatic t_access_result predict_access(input logic [KEY_BITS-1:0] key);
        t_access_result res;
        int             found;
        int             victim;
        int unsigned    cap;
        res    = '0;
        found  = -1;
        victim = -1;
        cap    = (capacity_setting == 0) ? 1 :
                 (capacity_setting > MAX_ENTRIES) ? MAX_ENTRIES : capacity_setting;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (found < 0 && slot_valid[i] && key_store[i] == key) begin
                found = i;
            end
        end
        if (found >= 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_valid[i] && slot_age[i] < slot_age[found]) begin
                    slot_age[i]++;
                end
            end
            slot_age[found] = 3'd0;
            res.hit = 1'b1;
            return res;
        end
        if (fill_level >= cap) begin
            // oldest valid slot; ties go to the higher index
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_valid[i] && (victim < 0 || slot_age[i] >= slot_age[victim])) begin
                    victim = i;
                end
            end
            if (victim >= 0) begin
                res.evicted     = 1'b1;
                res.evicted_key = key_store[victim];
                slot_valid[victim] = 1'b0;
                fill_level--;
            end
        end
        if (victim < 0) begin
            for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
                if (!slot_valid[i]) begin
                    victim = i;
                end
            end
        end
        if (victim >= 0) begin
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (slot_valid[i]) begin
                    slot_age[i]++;
                end
            end
            key_store[victim]  = key;
            slot_valid[victim] = 1'b1;
            slot_age[victim]   = 3'd0;
            fill_level++;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [EVK_BITS-1:0] got,
                                   input logic [EVK_BITS-1:0] want);
        $display("ERROR result %0d: %s got %h, expected %h", results_checked, what, got, want);
        mismatch_count++;
    endtask

    // Offers one item and waits for it to be taken; valid stays high unless a gap follows.
    task automatic send_access(input logic [KEY_BITS-1:0] key);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= key;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(predict_access(key));
        items_sent++;
        if (src_gaps && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Only called with the tracker idle.
    task automatic cfg_write(input logic [CFG_BITS-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en      <= 1'b0;
        capacity_setting  = value;
        @(posedge i_clk);
    endtask

    task automatic new_hot_set(input int unsigned n);
        for (int i = 0; i < n; i++) begin
            hot_keys[i] = KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
        end
        hot_count = n;
    endtask

    // Mostly a small working set so hits and evictions both happen.
    function automatic logic [KEY_BITS-1:0] pick_key();
        if ($urandom_range(0, 9) < 7) begin
            return hot_keys[$urandom_range(0, hot_count - 1)];
        end
        return KEY_BITS'($urandom_range(0, (1 << KEY_BITS) - 1));
    endfunction

    task automatic test_reset_capacity();
        send_access(16'h0000);
        send_access(16'hFFFF);
        send_access(16'h0000);
        wait_drain();
    endtask

    // zero acts as one, and the fill already exceeds it
    task automatic test_min_capacity();
        cfg_write(4'd0);
        send_access(16'hA5A5);
        send_access(16'hA5A5);
        send_access(16'h5A5A);
        wait_drain();
        cfg_write(4'd1);
        send_access(16'h0001);
        wait_drain();
    endtask

    // 15 is clamped to the store size: fill to eight, then misses evict
    task automatic test_max_capacity();
        cfg_write(4'd15);
        for (int i = 1; i <= 6; i++) begin
            send_access(KEY_BITS'(16'h1111 * i));
        end
        send_access(16'h5A5A);
        send_access(16'hC3C3);
        send_access(16'h3C3C);
        wait_drain();
    endtask

    // capacity below the fill: one eviction per miss, fill unchanged
    task automatic test_lowered_capacity();
        cfg_write(4'd3);
        send_access(16'hFEDC);
        send_access(16'h0123);
        send_access(16'h4444);
        send_access(16'h8000);
        wait_drain();
    endtask

    task automatic test_random_phases();
        logic [CFG_BITS-1:0] caps [6];
        caps    = '{4'd8, 4'd0, 4'd15, 4'd1, 4'd4, 4'd0};
        caps[5] = CFG_BITS'($urandom_range(0, 15));
        for (int p = 0; p < 6; p++) begin
            cfg_write(caps[p]);
            new_hot_set($urandom_range(2, 12));
            for (int n = 0; n < 100; n++) begin
                send_access(pick_key());
            end
            wait_drain();
        end
    endtask

    // sink holds off while the source keeps offering, so the input backs up
    task automatic test_output_stall();
        cfg_write(4'd8);
        new_hot_set(10);
        src_gaps      = 1'b0;
        sink_hold_req = 1'b1;
        for (int n = 0; n < 30; n++) begin
            send_access(pick_key());
        end
        src_gaps = 1'b1;
        wait_drain();
    endtask

    task automatic test_input_pause();
        cfg_write(4'd6);
        new_hot_set(8);
        for (int n = 0; n < 40; n++) begin
            send_access(pick_key());
        end
        wait_drain();
        for (int n = 0; n < 40; n++) begin
            send_access(pick_key());
        end
        wait_drain();
    endtask

    task automatic test_no_idle();
        src_gaps  = 1'b0;
        sink_gaps = 1'b0;
        cfg_write(4'd5);
        new_hot_set(7);
        for (int n = 0; n < 150; n++) begin
            send_access(pick_key());
        end
        wait_drain();
    endtask

    // result sink: random stall bursts plus an on-request long hold
    always @(posedge i_clk) begin
        if (sink_hold_req) begin
            sink_hold_req = 1'b0;
            hold_left     = LONG_HOLD;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 9) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no access pending", m_axis_tdata, '0);
            end else begin
                result_want = pending_results.pop_front();
                if (m_axis_tuser[0] !== result_want.hit) begin
                    report_mismatch("hit", EVK_BITS'(m_axis_tuser[0]),
                                    EVK_BITS'(result_want.hit));
                end
                if (m_axis_tuser[1] !== result_want.evicted) begin
                    report_mismatch("evicted", EVK_BITS'(m_axis_tuser[1]),
                                    EVK_BITS'(result_want.evicted));
                end
                if (m_axis_tdata !== result_want.evicted_key) begin
                    report_mismatch("evicted_key", m_axis_tdata, result_want.evicted_key);
                end
                hits_seen      += 32'(result_want.hit);
                evictions_seen += 32'(result_want.evicted);
            end
            results_checked++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending_results.size());
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_capacity();
        test_min_capacity();
        test_max_capacity();
        test_lowered_capacity();
        test_random_phases();
        test_output_stall();
        test_input_pause();
        test_no_idle();
        $display("%0d accesses sent, %0d results checked (%0d hits, %0d evictions)",
                 items_sent, results_checked, hits_seen, evictions_seen);
        $display("capacities 0, 1, 3, 4, 5, 6, 8, 15 and random; long output stall, input pause");
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/lkt_pkg.sv
src/lkt_ctrl.sv
src/lkt_dpath.sv
src/lru_key_tracker.sv
tb/lru_key_tracker_tb.sv
